// ----- src/tfn_pkg.sv -----
// shared types and constants of the triangle face normal engine
package tfn_pkg;

  typedef logic signed [31:0] q16_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TRI  = 1'b1;

  localparam int MAG_W       = 30;
  localparam int LEN_W       = 31;
  localparam int N2_W        = 62;
  localparam int QUO_W       = 17;
  localparam int SQRT_STAGES = 31;
  localparam int DIV_STAGES  = 17;
  localparam int REM_W       = 50;
  localparam int DV_W        = 32;

  localparam logic [33:0] THIRD_RECIP = 34'd11453246123;
  localparam int THIRD_SHIFT = 35;
  localparam logic signed [17:0] UNIT_ONE = 18'sd65536;

  typedef struct packed {
    logic       opcode;
    logic [9:0] vertex_slot;
    q16_t       pos_x;
    q16_t       pos_y;
    q16_t       pos_z;
    logic [9:0] corner_a;
    logic [9:0] corner_b;
    logic [9:0] corner_c;
  } item_t;

  typedef struct packed {
    q16_t center_x;
    q16_t center_y;
    q16_t center_z;
    q16_t tip_x;
    q16_t tip_y;
    q16_t tip_z;
  } result_t;

  typedef struct packed {
    q16_t [2:0]            ctr;
    logic [2:0][MAG_W-1:0] cmag;
    logic [2:0]            cneg;
  } carry_t;

endpackage

// ----- src/tfn_sqrt.sv -----
// pipelined integer square root, one root bit per stage
module tfn_sqrt import tfn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [N2_W-1:0]  n2,
  input  carry_t           in_carry,
  output logic             out_valid,
  output logic [LEN_W-1:0] len,
  output carry_t           out_carry
);

  logic             vld_q [SQRT_STAGES];
  logic [N2_W-1:0]  rem_q [SQRT_STAGES];
  logic [LEN_W-1:0] root_q [SQRT_STAGES];
  carry_t           cry_q [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - g;
    logic             cv;
    logic [N2_W-1:0]  crem;
    logic [LEN_W-1:0] croot;
    carry_t           ccry;
    logic [63:0]      test;
    logic             take;

    if (g == 0) begin : g_first
      assign cv    = in_valid;
      assign crem  = n2;
      assign croot = '0;
      assign ccry  = in_carry;
    end else begin : g_next
      assign cv    = vld_q[g-1];
      assign crem  = rem_q[g-1];
      assign croot = root_q[g-1];
      assign ccry  = cry_q[g-1];
    end

    assign test = (64'(croot) << (B + 1)) | (64'd1 << (2 * B));
    assign take = 64'(crem) >= test;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (adv) begin
        vld_q[g] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[g]  <= take ? crem - test[N2_W-1:0] : crem;
        root_q[g] <= take ? (croot | (LEN_W'(1) << B)) : croot;
        cry_q[g]  <= ccry;
      end
    end
  end

  assign out_valid = vld_q[SQRT_STAGES-1];
  assign len       = root_q[SQRT_STAGES-1];
  assign out_carry = cry_q[SQRT_STAGES-1];

endmodule

// ----- src/tfn_div.sv -----
// pipelined rounded division of the three normal components by the length
module tfn_div import tfn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [LEN_W-1:0]      len,
  input  carry_t                in_carry,
  output logic                  out_valid,
  output logic [2:0][QUO_W-1:0] quo,
  output logic                  out_zero,
  output carry_t                out_carry
);

  logic                  vld_q [DIV_STAGES];
  logic [2:0][REM_W-1:0] rem_q [DIV_STAGES];
  logic [2:0][QUO_W-1:0] quo_q [DIV_STAGES];
  logic [DV_W-1:0]       dv_q  [DIV_STAGES];
  logic                  zr_q  [DIV_STAGES];
  carry_t                cry_q [DIV_STAGES];

  // rounded quotient is floor((2 * mag * 2^16 + len) / (2 * len))
  logic [2:0][REM_W-1:0] rem_init;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_init[i] = REM_W'({in_carry.cmag[i], 17'd0}) + REM_W'(len);
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    localparam int B = DIV_STAGES - 1 - g;
    logic                  cv;
    logic [2:0][REM_W-1:0] crem;
    logic [2:0][QUO_W-1:0] cquo;
    logic [DV_W-1:0]       cdv;
    logic                  czr;
    carry_t                ccry;
    logic [REM_W-1:0]      sub;
    logic [2:0][REM_W-1:0] nrem;
    logic [2:0][QUO_W-1:0] nquo;

    if (g == 0) begin : g_first
      assign cv   = in_valid;
      assign crem = rem_init;
      assign cquo = '0;
      assign cdv  = {len, 1'b0};
      assign czr  = (len == '0);
      assign ccry = in_carry;
    end else begin : g_next
      assign cv   = vld_q[g-1];
      assign crem = rem_q[g-1];
      assign cquo = quo_q[g-1];
      assign cdv  = dv_q[g-1];
      assign czr  = zr_q[g-1];
      assign ccry = cry_q[g-1];
    end

    assign sub = REM_W'(cdv) << B;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (crem[i] >= sub) begin
          nrem[i] = crem[i] - sub;
          nquo[i] = cquo[i] | (QUO_W'(1) << B);
        end else begin
          nrem[i] = crem[i];
          nquo[i] = cquo[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (adv) begin
        vld_q[g] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[g] <= nrem;
        quo_q[g] <= nquo;
        dv_q[g]  <= cdv;
        zr_q[g]  <= czr;
        cry_q[g] <= ccry;
      end
    end
  end

  assign out_valid = vld_q[DIV_STAGES-1];
  assign quo       = quo_q[DIV_STAGES-1];
  assign out_zero  = zr_q[DIV_STAGES-1];
  assign out_carry = cry_q[DIV_STAGES-1];

endmodule

// ----- src/triangle_face_normal.sv -----
// Triangle face normal engine: a load transaction writes one vertex into the
// vertex store; a triangle transaction reads three vertices and returns the
// centroid and the centroid plus the unit face normal, all signed Q16.16.
// The pipeline takes one transaction per cycle unless the output stalls;
// its depth is set by the 31-stage square root and the 17-stage divider.
// The store is held in three copies so that the three corners are read in
// the same cycle. Loads give no result, and a triangle may use a vertex
// loaded in the cycle before. The whole pipeline stalls while a result
// waits at the output.
module triangle_face_normal import tfn_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int ADDR_W = $clog2(VERTEX_DEPTH);

  logic adv;
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;

  // vertex store, one copy per corner
  logic [95:0] mem_a [VERTEX_DEPTH];
  logic [95:0] mem_b [VERTEX_DEPTH];
  logic [95:0] mem_c [VERTEX_DEPTH];

  logic [16:0] slot_ext, ca_ext, cb_ext, cc_ext;
  logic        wr_en;
  assign slot_ext = 17'(item.vertex_slot);
  assign ca_ext   = 17'(item.corner_a);
  assign cb_ext   = 17'(item.corner_b);
  assign cc_ext   = 17'(item.corner_c);
  assign wr_en    = item_valid && adv && (item.opcode == OP_LOAD)
                    && (slot_ext < 17'(VERTEX_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[slot_ext[ADDR_W-1:0]] <= {item.pos_z, item.pos_y, item.pos_x};
      mem_b[slot_ext[ADDR_W-1:0]] <= {item.pos_z, item.pos_y, item.pos_x};
      mem_c[slot_ext[ADDR_W-1:0]] <= {item.pos_z, item.pos_y, item.pos_x};
    end
  end

  // stage 1: store read
  logic        s1_valid;
  logic [95:0] rd_a, rd_b, rd_c;
  logic [2:0]  s1_ok;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_a  <= mem_a[ca_ext[ADDR_W-1:0]];
      rd_b  <= mem_b[cb_ext[ADDR_W-1:0]];
      rd_c  <= mem_c[cc_ext[ADDR_W-1:0]];
      s1_ok <= {cc_ext < 17'(VERTEX_DEPTH), cb_ext < 17'(VERTEX_DEPTH),
                ca_ext < 17'(VERTEX_DEPTH)};
    end
  end

  // stage 2: edges and coordinate sums
  logic        s2_valid;
  logic signed [32:0] s2_ev [3];
  logic signed [32:0] s2_ew [3];
  logic signed [33:0] s2_sum [3];
  logic [95:0] va, vb, vc;
  q16_t p0 [3];
  q16_t p1 [3];
  q16_t p2 [3];

  always_comb begin
    va = s1_ok[0] ? rd_a : '0;
    vb = s1_ok[1] ? rd_b : '0;
    vc = s1_ok[2] ? rd_c : '0;
    for (int i = 0; i < 3; i++) begin
      p0[i] = $signed(va[32*i +: 32]);
      p1[i] = $signed(vb[32*i +: 32]);
      p2[i] = $signed(vc[32*i +: 32]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_ev[i]  <= 33'(p1[i]) - 33'(p0[i]);
        s2_ew[i]  <= 33'(p2[i]) - 33'(p0[i]);
        s2_sum[i] <= 34'(p0[i]) + 34'(p1[i]) + 34'(p2[i]);
      end
    end
  end

  // stage 3: edge scaling below 2^30, centroid reciprocal product
  logic        s3_valid;
  logic signed [30:0] s3_ev [3];
  logic signed [30:0] s3_ew [3];
  logic [66:0] s3_cprod [3];
  logic [2:0]  s3_cneg;
  logic [32:0] mv [3];
  logic [32:0] mw [3];
  logic [32:0] or_v, or_w;
  logic [1:0]  sh_v, sh_w;
  logic signed [30:0] rv [3];
  logic signed [30:0] rw [3];
  logic [32:0] smag [3];

  always_comb begin
    or_v = '0;
    or_w = '0;
    for (int i = 0; i < 3; i++) begin
      mv[i] = s2_ev[i][32] ? 33'(-s2_ev[i]) : 33'(s2_ev[i]);
      mw[i] = s2_ew[i][32] ? 33'(-s2_ew[i]) : 33'(s2_ew[i]);
      or_v  = or_v | mv[i];
      or_w  = or_w | mw[i];
      smag[i] = s2_sum[i][33] ? 33'(-s2_sum[i]) : 33'(s2_sum[i]);
    end
    priority if (or_v[32:30] == '0) sh_v = 2'd0;
    else if (or_v[32:31] == '0) sh_v = 2'd1;
    else if (!or_v[32]) sh_v = 2'd2;
    else sh_v = 2'd3;
    priority if (or_w[32:30] == '0) sh_w = 2'd0;
    else if (or_w[32:31] == '0) sh_w = 2'd1;
    else if (!or_w[32]) sh_w = 2'd2;
    else sh_w = 2'd3;
    for (int i = 0; i < 3; i++) begin
      rv[i] = $signed({1'b0, 30'(mv[i] >> sh_v)});
      rw[i] = $signed({1'b0, 30'(mw[i] >> sh_w)});
      if (s2_ev[i][32]) rv[i] = -rv[i];
      if (s2_ew[i][32]) rw[i] = -rw[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s3_ev[i]    <= rv[i];
        s3_ew[i]    <= rw[i];
        s3_cprod[i] <= 67'(smag[i]) * 67'(THIRD_RECIP);
        s3_cneg[i]  <= s2_sum[i][33];
      end
    end
  end

  // stage 4: cross product terms, centroid
  logic        s4_valid;
  logic signed [61:0] s4_prod [6];
  q16_t        s4_ctr [3];
  logic [31:0] cq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cq[i] = s3_cprod[i][THIRD_SHIFT +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_prod[0] <= 62'(s3_ev[1]) * 62'(s3_ew[2]);
      s4_prod[1] <= 62'(s3_ev[2]) * 62'(s3_ew[1]);
      s4_prod[2] <= 62'(s3_ev[2]) * 62'(s3_ew[0]);
      s4_prod[3] <= 62'(s3_ev[0]) * 62'(s3_ew[2]);
      s4_prod[4] <= 62'(s3_ev[0]) * 62'(s3_ew[1]);
      s4_prod[5] <= 62'(s3_ev[1]) * 62'(s3_ew[0]);
      for (int i = 0; i < 3; i++) begin
        s4_ctr[i] <= s3_cneg[i] ? $signed(-cq[i]) : $signed(cq[i]);
      end
    end
  end

  // stage 5: cross product
  logic        s5_valid;
  logic signed [61:0] s5_cross [3];
  q16_t        s5_ctr [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_cross[i] <= s4_prod[2*i] - s4_prod[2*i+1];
        s5_ctr[i]   <= s4_ctr[i];
      end
    end
  end

  // stage 6: magnitudes and scaling count
  logic        s6_valid;
  logic [60:0] s6_mag [3];
  logic [2:0]  s6_neg;
  logic [4:0]  s6_shift;
  q16_t        s6_ctr [3];
  logic [60:0] cmag_w [3];
  logic [60:0] or_c;
  logic [4:0]  sh_c;

  always_comb begin
    or_c = '0;
    for (int i = 0; i < 3; i++) begin
      cmag_w[i] = s5_cross[i][61] ? 61'(-s5_cross[i]) : 61'(s5_cross[i]);
      or_c      = or_c | cmag_w[i];
    end
    sh_c = '0;
    for (int k = 31; k >= 0; k--) begin
      if ((or_c >> (30 + k)) == '0) sh_c = 5'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s6_mag[i] <= cmag_w[i];
        s6_neg[i] <= s5_cross[i][61];
        s6_ctr[i] <= s5_ctr[i];
      end
      s6_shift <= sh_c;
    end
  end

  // stage 7: scaled cross product
  logic   s7_valid;
  carry_t s7_carry;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s7_carry.cmag[i] <= MAG_W'(s6_mag[i] >> s6_shift);
        s7_carry.ctr[i]  <= s6_ctr[i];
      end
      s7_carry.cneg <= s6_neg;
    end
  end

  // stage 8: squares
  logic        s8_valid;
  logic [59:0] s8_sq [3];
  carry_t      s8_carry;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s8_sq[i] <= 60'(s7_carry.cmag[i]) * 60'(s7_carry.cmag[i]);
      end
      s8_carry <= s7_carry;
    end
  end

  // stage 9: squared length
  logic            s9_valid;
  logic [N2_W-1:0] s9_n2;
  carry_t          s9_carry;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_n2    <= N2_W'(s8_sq[0]) + N2_W'(s8_sq[1]) + N2_W'(s8_sq[2]);
      s9_carry <= s8_carry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      s9_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= item_valid && (item.opcode == OP_TRI);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
      s9_valid <= s8_valid;
    end
  end

  logic             rt_valid;
  logic [LEN_W-1:0] rt_len;
  carry_t           rt_carry;

  tfn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s9_valid),
    .n2        (s9_n2),
    .in_carry  (s9_carry),
    .out_valid (rt_valid),
    .len       (rt_len),
    .out_carry (rt_carry)
  );

  logic                  dv_valid;
  logic [2:0][QUO_W-1:0] dv_quo;
  logic                  dv_zero;
  carry_t                dv_carry;

  tfn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (rt_valid),
    .len       (rt_len),
    .in_carry  (rt_carry),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .out_zero  (dv_zero),
    .out_carry (dv_carry)
  );

  // final stage: unit normal, tip with saturation
  logic signed [17:0] nrm [3];
  logic signed [32:0] tsum [3];
  q16_t               tip [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero) begin
        nrm[i] = (i == 0) ? UNIT_ONE : '0;
      end else begin
        nrm[i] = $signed({1'b0, dv_quo[i]});
        if (dv_carry.cneg[i]) nrm[i] = -nrm[i];
      end
      tsum[i] = 33'(dv_carry.ctr[i]) + 33'(nrm[i]);
      if (tsum[i] > 33'sh0_7FFF_FFFF) begin
        tip[i] = 32'sh7FFF_FFFF;
      end else if (tsum[i] < -33'sh0_8000_0000) begin
        tip[i] = 32'sh8000_0000;
      end else begin
        tip[i] = tsum[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.center_x <= dv_carry.ctr[0];
      result.center_y <= dv_carry.ctr[1];
      result.center_z <= dv_carry.ctr[2];
      result.tip_x    <= tip[0];
      result.tip_y    <= tip[1];
      result.tip_z    <= tip[2];
    end
  end

endmodule

// ----- src/tfn_check.sv -----
// port-level checks of the triangle face normal engine and their binding
module tfn_check import tfn_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  logic signed [32:0] dx;
  assign dx = 33'(result.tip_x) - 33'(result.center_x);

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // an empty output stage never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input blocked with empty output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled transaction changed");

  // offered input transaction waits unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("offered transaction changed");

  // x of the tip stays within one unit of the centroid's x unless it saturated
  a_unit_x: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (dx <= 33'sd65536 && dx >= -33'sd65536)
      || result.tip_x == 32'sh7FFF_FFFF || result.tip_x == 32'sh8000_0000)
    else $error("normal x out of unit range");

endmodule

bind triangle_face_normal tfn_check u_tfn_check (.*);

// ----- tb/sv/triangle_face_normal_tb.sv -----
// testbench for the triangle face normal engine: directed and random loads and triangles
`timescale 1ns / 1ps

import tfn_pkg::*;

class normal_scoreboard;
  logic signed [31:0] px[1024];
  logic signed [31:0] py[1024];
  logic signed [31:0] pz[1024];
  result_t pending[$];
  int errors;
  int triangles;
  int loads;

  function new();
    errors = 0;
    triangles = 0;
    loads = 0;
    for (int i = 0; i < 1024; i++) begin
      px[i] = 0;
      py[i] = 0;
      pz[i] = 0;
    end
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void shrink(ref logic signed [63:0] v[3]);
    logic [63:0] mx;
    int s;
    mx = magnitude(v[0]);
    s = 0;
    if (magnitude(v[1]) > mx) mx = magnitude(v[1]);
    if (magnitude(v[2]) > mx) mx = magnitude(v[2]);
    while ((mx >> s) >= 64'd1 << 30) s++;
    for (int i = 0; i < 3; i++) begin
      if (v[i] < 0) v[i] = -$signed(magnitude(v[i]) >> s);
      else v[i] = $signed(magnitude(v[i]) >> s);
    end
  endfunction

  function automatic logic [63:0] root(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void note_item(item_t it);
    logic signed [63:0] p[3][3];
    logic signed [63:0] ev[3], ew[3], cr[3], nrm[3], ctr[3], tip[3], sum;
    logic [63:0] n2, len, num, q;
    logic [9:0] idx[3];
    result_t r;
    if (it.opcode == OP_LOAD) begin
      px[it.vertex_slot] = it.pos_x;
      py[it.vertex_slot] = it.pos_y;
      pz[it.vertex_slot] = it.pos_z;
      loads++;
      return;
    end
    idx[0] = it.corner_a;
    idx[1] = it.corner_b;
    idx[2] = it.corner_c;
    for (int k = 0; k < 3; k++) begin
      p[k][0] = px[idx[k]];
      p[k][1] = py[idx[k]];
      p[k][2] = pz[idx[k]];
    end
    for (int i = 0; i < 3; i++) begin
      ev[i] = p[1][i] - p[0][i];
      ew[i] = p[2][i] - p[0][i];
    end
    shrink(ev);
    shrink(ew);
    cr[0] = ev[1] * ew[2] - ev[2] * ew[1];
    cr[1] = ev[2] * ew[0] - ev[0] * ew[2];
    cr[2] = ev[0] * ew[1] - ev[1] * ew[0];
    shrink(cr);
    n2 = 0;
    for (int i = 0; i < 3; i++) n2 += magnitude(cr[i]) * magnitude(cr[i]);
    len = root(n2);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        nrm[i] = (i == 0) ? 64'sd65536 : 64'sd0;
      end else begin
        num = magnitude(cr[i]) << 16;
        if (len[0] == 1'b0) q = (num + (len >> 1)) / len;
        else q = (2 * num + len) / (2 * len);
        nrm[i] = cr[i] < 0 ? -$signed(q) : $signed(q);
      end
      sum = p[0][i] + p[1][i] + p[2][i];
      ctr[i] = clamp(sum / 3);
      tip[i] = clamp(ctr[i] + nrm[i]);
    end
    r.center_x = ctr[0][31:0];
    r.center_y = ctr[1][31:0];
    r.center_z = ctr[2][31:0];
    r.tip_x = tip[0][31:0];
    r.tip_y = tip[1][31:0];
    r.tip_z = tip[2][31:0];
    pending = {pending, r};
    triangles++;
  endfunction

  function automatic void check_result(result_t got);
    result_t w;
    if (pending.size() == 0) begin
      $error("result with nothing pending: %h", got);
      errors++;
      return;
    end
    w = pending.pop_front();
    if (got.center_x !== w.center_x) begin
      $error("center_x exp %h got %h", w.center_x, got.center_x); errors++;
    end
    if (got.center_y !== w.center_y) begin
      $error("center_y exp %h got %h", w.center_y, got.center_y); errors++;
    end
    if (got.center_z !== w.center_z) begin
      $error("center_z exp %h got %h", w.center_z, got.center_z); errors++;
    end
    if (got.tip_x !== w.tip_x) begin
      $error("tip_x exp %h got %h", w.tip_x, got.tip_x); errors++;
    end
    if (got.tip_y !== w.tip_y) begin
      $error("tip_y exp %h got %h", w.tip_y, got.tip_y); errors++;
    end
    if (got.tip_z !== w.tip_z) begin
      $error("tip_z exp %h got %h", w.tip_z, got.tip_z); errors++;
    end
  endfunction
endclass

module triangle_face_normal_tb;
  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 0;
  result_t result;

  normal_scoreboard sb = new();
  bit written[1024];
  int written_list[$];
  bit calm_in = 0;
  bit calm_out = 0;
  bit hold_out = 0;

  triangle_face_normal dut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready),
    .item(item), .result_valid(result_valid), .result_ready(result_ready),
    .result(result)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 2000) - 1000;
      3: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0] pick_written();
    return 10'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  task automatic send(item_t it);
    if (!calm_in) begin
      while ($urandom_range(0, 99) < 20) begin
        item_valid <= 0;
        @(negedge clk);
      end
    end
    item <= it;
    item_valid <= 1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
    if (it.opcode == OP_LOAD && !written[it.vertex_slot]) begin
      written[it.vertex_slot] = 1;
      written_list = {written_list, int'(it.vertex_slot)};
    end
    @(negedge clk);
  endtask

  task automatic load(logic [9:0] slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    item_t it;
    it = '0;
    it.opcode = OP_LOAD;
    it.vertex_slot = slot;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.corner_a = 10'($urandom);
    it.corner_b = 10'($urandom);
    it.corner_c = 10'($urandom);
    send(it);
  endtask

  task automatic tri_item(logic [9:0] a, logic [9:0] b, logic [9:0] c);
    item_t it;
    it = '0;
    it.opcode = OP_TRI;
    it.vertex_slot = 10'($urandom);
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    it.corner_a = a;
    it.corner_b = b;
    it.corner_c = c;
    send(it);
  endtask

  // receiver
  always @(negedge clk) begin
    if (rst || hold_out) result_ready <= 0;
    else if (calm_out) result_ready <= 1;
    else result_ready <= ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // long receiver stall so the pipeline backs up
  initial begin
    wait (sb.triangles > 300);
    @(negedge clk);
    hold_out = 1;
    repeat (200) @(negedge clk);
    hold_out = 0;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int s;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed: extremes and special cases
    load(10'd0, 32'h00000000, 32'h00000000, 32'h00000000);
    load(10'd1, 32'h00010000, 32'h00000000, 32'h00000000);
    load(10'd2, 32'h00000000, 32'h00010000, 32'h00000000);
    load(10'd1023, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    load(10'd1022, 32'h80000000, 32'h80000000, 32'h80000000);
    load(10'd3, 32'h7fffffff, 32'h80000000, 32'h00000000);
    load(10'd4, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    load(10'd5, 32'h00020000, 32'h00020000, 32'h00000000);
    tri_item(10'd0, 10'd1, 10'd2);
    tri_item(10'd0, 10'd0, 10'd0);
    tri_item(10'd1, 10'd0, 10'd5);
    tri_item(10'd1023, 10'd1023, 10'd1023);
    tri_item(10'd1022, 10'd1022, 10'd1022);
    tri_item(10'd1023, 10'd1022, 10'd3);
    tri_item(10'd3, 10'd4, 10'd1022);
    tri_item(10'd4, 10'd3, 10'd1023);
    tri_item(10'd2, 10'd1, 10'd0);
    load(10'd6, 32'h7fffffff, 32'h7fffffff, 32'h7ffffff0);
    tri_item(10'd6, 10'd1023, 10'd6);
    tri_item(10'd6, 10'd1023, 10'd1022);
    // random part; middle stretch has no idling
    for (int n = 0; n < 1800; n++) begin
      calm_in = (n >= 700 && n < 950);
      calm_out = calm_in;
      if ($urandom_range(0, 99) < 35) begin
        s = $urandom_range(0, 1023);
        if ($urandom_range(0, 3) == 0) s = $urandom_range(0, 15);
        load(10'(s), pick_coord(), pick_coord(), pick_coord());
      end else begin
        tri_item(pick_written(), pick_written(), pick_written());
      end
    end
    item_valid <= 0;
    calm_in = 0;
    calm_out = 0;
    s = 0;
    while (sb.pending.size() != 0 && s < 100000) begin
      @(posedge clk);
      s++;
    end
    repeat (100) @(posedge clk);
    $display("covered %0d loads and %0d triangles, %0d vertex slots written",
             sb.loads, sb.triangles, written_list.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- files.f -----
src/tfn_pkg.sv
src/tfn_sqrt.sv
src/tfn_div.sv
src/triangle_face_normal.sv
src/tfn_check.sv
tb/sv/triangle_face_normal_tb.sv
